// ===== rtl/core/sacm_pkg.sv =====
// Shared types and constants of the set-associative cache tag model.
package sacm_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_LINE_SIZE_LOG2 = 3'd0;
   localparam logic [2:0] CSR_SET_COUNT_LOG2 = 3'd1;
   localparam logic [2:0] CSR_WAYS_IN_USE    = 3'd2;
   localparam logic [2:0] CSR_WRITE_POLICY   = 3'd3;
   localparam logic [2:0] CSR_REPLACE_POLICY = 3'd4;
   localparam logic [2:0] CSR_HIT_TIME       = 3'd5;
   localparam logic [2:0] CSR_MISS_PENALTY   = 3'd6;

   // Policy codes
   localparam logic       WP_WRITE_BACK    = 1'b0;
   localparam logic       WP_WRITE_THROUGH = 1'b1;
   localparam logic [1:0] RP_RANDOM        = 2'd0;
   localparam logic [1:0] RP_FIFO          = 2'd1;
   localparam logic [1:0] RP_LRU           = 2'd2;

   // Random victim generator
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic [2:0]  line_size_log2;
      logic [3:0]  set_count_log2;
      logic [3:0]  ways_in_use;
      logic        write_policy;
      logic [1:0]  replace_policy;
      logic [15:0] hit_time;
      logic [15:0] miss_penalty;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [47:0] elapsed_time;
      logic [47:0] total_access_time;
   } rsp_type;

   // One step of the Galois LFSR
   function automatic logic [15:0] lfsr_step(input logic [15:0] x);
      logic [15:0] y;
      y = x >> 1;
      if (x[0]) begin
         y = y ^ LFSR_TAPS;
      end
      return y;
   endfunction

endpackage

// ===== rtl/core/sacm_front.sv =====
// Front end: splits each address into set and tag and queues the transaction.
module sacm_front #(
   parameter int MAX_SETS  = 256,
   parameter int ADDR_BITS = 32,
   parameter int SET_W     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sacm_pkg::cfg_type     cfg,
   input  logic                  push,
   output logic                  full,
   input  logic [ADDR_BITS-1:0]  address,
   input  logic                  mode,
   output logic                  empty,
   input  logic                  pop,
   output logic [SET_W-1:0]      head_set,
   output logic [ADDR_BITS-1:0]  head_tag,
   output logic                  head_mode
);
   import sacm_pkg::*;

   localparam int SL_MAX = $clog2(MAX_SETS);

   logic [ADDR_BITS-1:0] line_no;
   logic [3:0]           sl;
   logic [SET_W:0]       mask_wide;
   logic [SET_W-1:0]     set_c;
   logic [ADDR_BITS-1:0] tag_c;

   logic [SET_W-1:0]     set_ff  [2];
   logic [ADDR_BITS-1:0] tag_ff  [2];
   logic                 mode_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   // Address split under the current geometry
   always_comb begin
      line_no   = address >> cfg.line_size_log2;
      sl        = (cfg.set_count_log2 > 4'(SL_MAX)) ? 4'(SL_MAX) : cfg.set_count_log2;
      mask_wide = {(SET_W+1){1'b1}} << sl;
      set_c     = line_no[SET_W-1:0] & ~mask_wide[SET_W-1:0];
      tag_c     = line_no >> sl;
   end

   assign full      = (cnt_ff == 2'd2);
   assign empty     = (cnt_ff == 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_set  = set_ff[rd_ptr_ff];
   assign head_tag  = tag_ff[rd_ptr_ff];
   assign head_mode = mode_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         set_ff[wr_ptr_ff]  <= set_c;
         tag_ff[wr_ptr_ff]  <= tag_c;
         mode_ff[wr_ptr_ff] <= mode;
      end
   end

endmodule

// ===== rtl/core/sacm_back.sv =====
// Back end: tag store lookup, victim choice, fill, counters and result queue.
module sacm_back #(
   parameter int MAX_WAYS   = 8,
   parameter int MAX_SETS   = 256,
   parameter int ADDR_BITS  = 32,
   parameter int STAMP_BITS = 48,
   parameter int SET_W      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sacm_pkg::cfg_type     cfg,
   input  logic                  cfg_write,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic [SET_W-1:0]      q_set,
   input  logic [ADDR_BITS-1:0]  q_tag,
   input  logic                  q_mode,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sacm_pkg::rsp_type     rsp
);
   import sacm_pkg::*;

   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam int REM_W = CNT_W + 1;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_type;

   // Tag store memories, one row per set
   logic [MAX_WAYS-1:0]   valid_mem  [MAX_SETS];
   logic [ADDR_BITS-1:0]  tag_mem    [MAX_WAYS][MAX_SETS];
   logic [STAMP_BITS-1:0] sstamp_mem [MAX_WAYS][MAX_SETS];
   logic [STAMP_BITS-1:0] astamp_mem [MAX_WAYS][MAX_SETS];

   logic [MAX_WAYS-1:0]   valid_rd;
   logic [ADDR_BITS-1:0]  tag_rd    [MAX_WAYS];
   logic [STAMP_BITS-1:0] sstamp_rd [MAX_WAYS];
   logic [STAMP_BITS-1:0] astamp_rd [MAX_WAYS];

   state_type             state_ff;
   logic [SET_W-1:0]      clr_ff;
   logic [SET_W-1:0]      set_ff;
   logic [ADDR_BITS-1:0]  tag_ff;
   logic                  mode_ff;
   logic [SET_W-1:0]      rd_set;

   logic [STAMP_BITS-1:0] clock_ff, clock_in;
   logic [31:0]           hits_ff, hits_in, misses_ff, misses_in;
   logic [47:0]           wtime_ff, wtime_in;
   logic [15:0]           lfsr_ff;

   // Remainder unit for the random victim
   logic [15:0]           mod_num;
   logic [4:0]            mod_cnt_ff;
   logic [REM_W-1:0]      mod_rem_ff, mod_rem_in;
   logic                  mod_done;

   // Lookup decisions
   logic [CNT_W-1:0]      ways_eff;
   logic [MAX_WAYS-1:0]   hit_vec;
   logic                  hit;
   logic [WAY_W-1:0]      hit_way;
   logic                  inv_found;
   logic [WAY_W-1:0]      inv_way;
   logic [STAMP_BITS-1:0] best;
   logic [WAY_W-1:0]      min_way;
   logic                  use_rand;
   logic [WAY_W-1:0]      victim;
   logic                  step_go;
   logic [STAMP_BITS-1:0] clk_hit, clk_miss;

   // Result queue
   rsp_type               oq_ff [2];
   logic                  owr_ff, ord_ff;
   logic [1:0]            ocnt_ff;
   rsp_type               res;

   assign ways_eff = (cfg.ways_in_use == 4'd0) ? CNT_W'(1) :
                     (32'(cfg.ways_in_use) > MAX_WAYS) ? CNT_W'(MAX_WAYS) :
                     CNT_W'(cfg.ways_in_use);

   assign q_pop  = (state_ff == S_IDLE) && !q_empty && (ocnt_ff != 2'd2);
   assign rd_set = q_pop ? q_set : set_ff;

   // Hit detection, first free way and oldest stamp
   always_comb begin
      hit_vec   = '0;
      hit       = 1'b0;
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      best      = (cfg.replace_policy == RP_FIFO) ? sstamp_rd[0] : astamp_rd[0];
      min_way   = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w] = (CNT_W'(w) < ways_eff) && valid_rd[w] && (tag_rd[w] == tag_ff);
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if ((CNT_W'(w) < ways_eff) && !valid_rd[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (CNT_W'(w) < ways_eff) begin
            if (cfg.replace_policy == RP_FIFO) begin
               if (sstamp_rd[w] < best) begin
                  best    = sstamp_rd[w];
                  min_way = WAY_W'(w);
               end
            end else begin
               if (astamp_rd[w] < best) begin
                  best    = astamp_rd[w];
                  min_way = WAY_W'(w);
               end
            end
         end
      end
   end

   always_comb begin
      use_rand = !hit && !inv_found && (ways_eff > CNT_W'(1)) &&
                 (cfg.replace_policy == RP_RANDOM);
      if (inv_found) begin
         victim = inv_way;
      end else if (ways_eff == CNT_W'(1)) begin
         victim = '0;
      end else if (cfg.replace_policy == RP_RANDOM) begin
         victim = WAY_W'(mod_rem_ff);
      end else begin
         victim = min_way;
      end
      step_go  = (state_ff == S_LOOK) && (!use_rand || mod_done);
      clk_hit  = clock_ff + STAMP_BITS'(1);
      clk_miss = clock_ff + STAMP_BITS'(2);
   end

   // Clock, counters and result of this transaction
   always_comb begin
      if (hit) begin
         clock_in = clk_hit + ((mode_ff && cfg.write_policy == WP_WRITE_THROUGH) ?
                               STAMP_BITS'(2) : STAMP_BITS'(0));
         hits_in   = hits_ff + 32'd1;
         misses_in = misses_ff;
         wtime_in  = wtime_ff + 48'(cfg.hit_time);
      end else begin
         clock_in = clk_miss + ((mode_ff && cfg.write_policy == WP_WRITE_BACK) ?
                                STAMP_BITS'(2) : STAMP_BITS'(0));
         hits_in   = hits_ff;
         misses_in = misses_ff + 32'd1;
         wtime_in  = wtime_ff + 48'(cfg.miss_penalty);
      end
      res.hit               = hit;
      res.hit_count         = hits_in;
      res.miss_count        = misses_in;
      res.elapsed_time      = 48'(clock_in);
      res.total_access_time = wtime_in;
   end

   // Sequencer and registered state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         clock_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         wtime_ff  <= '0;
         lfsr_ff   <= LFSR_SEED;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SET_W'(1);
               if (32'(clr_ff) == MAX_SETS - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               if (step_go) begin
                  state_ff  <= S_IDLE;
                  clock_ff  <= clock_in;
                  hits_ff   <= hits_in;
                  misses_ff <= misses_in;
                  wtime_ff  <= wtime_in;
                  if (use_rand) begin
                     lfsr_ff <= lfsr_step(lfsr_ff);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         set_ff  <= q_set;
         tag_ff  <= q_tag;
         mode_ff <= q_mode;
      end
   end

   // Bit-serial remainder of the next LFSR value by the ways in use
   assign mod_num  = lfsr_step(lfsr_ff);
   assign mod_done = (mod_cnt_ff == 5'd16);

   always_comb begin
      mod_rem_in = {mod_rem_ff[REM_W-2:0], mod_num[4'(15 - mod_cnt_ff[3:0])]};
      if (mod_rem_in >= REM_W'(ways_eff)) begin
         mod_rem_in = mod_rem_in - REM_W'(ways_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_write || (step_go && use_rand)) begin
         mod_cnt_ff <= '0;
         mod_rem_ff <= '0;
      end else if (!mod_done) begin
         mod_cnt_ff <= mod_cnt_ff + 5'd1;
         mod_rem_ff <= mod_rem_in;
      end
   end

   // Memory reads
   always_ff @(posedge clock) begin
      valid_rd <= valid_mem[rd_set];
      for (int w = 0; w < MAX_WAYS; w++) begin
         tag_rd[w]    <= tag_mem[w][rd_set];
         sstamp_rd[w] <= sstamp_mem[w][rd_set];
         astamp_rd[w] <= astamp_mem[w][rd_set];
      end
   end

   // Memory writes: clearing pass, hit refresh, fill
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         valid_mem[clr_ff] <= '0;
      end else if (step_go) begin
         if (hit) begin
            astamp_mem[hit_way][set_ff] <= clk_hit;
         end else begin
            valid_mem[set_ff]          <= valid_rd | (MAX_WAYS'(1) << victim);
            tag_mem[victim][set_ff]    <= tag_ff;
            sstamp_mem[victim][set_ff] <= clk_miss;
            astamp_mem[victim][set_ff] <= clk_miss;
         end
      end
   end

   // Result queue
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp       = oq_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (step_go) begin
            owr_ff <= !owr_ff;
         end
         if (rsp_pop && !rsp_empty) begin
            ord_ff <= !ord_ff;
         end
         ocnt_ff <= ocnt_ff + 2'(step_go) - 2'(rsp_pop && !rsp_empty);
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         oq_ff[owr_ff] <= res;
      end
   end

endmodule

// ===== rtl/core/set_assoc_cache_tag_model_core.sv =====
// Top level of the set-associative cache tag model: registers and the two halves.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_push / req_full| req_address, req_mode
//   rsp     | out       | rsp_pop / rsp_empty| rsp_hit, counts, times
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// In the back end a transaction reads its set in S_IDLE, then compares, picks a
// victim and writes the set in S_LOOK. A random victim holds the lookup until the
// bit-serial remainder unit has run its 16 steps, so a random replacement right
// after another waits for it to run again. After reset a clearing pass over all
// MAX_SETS sets runs before the first lookup. Each side has a two-entry queue, so
// the front takes requests while results wait to be popped, till both fill.
module set_assoc_cache_tag_model_core #(
   parameter int MAX_WAYS   = 8,
   parameter int MAX_SETS   = 256,
   parameter int ADDR_BITS  = 32,
   parameter int STAMP_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic                 req_mode,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_hit,
   output logic [31:0]          rsp_hit_count,
   output logic [31:0]          rsp_miss_count,
   output logic [47:0]          rsp_elapsed_time,
   output logic [47:0]          rsp_total_access_time,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import sacm_pkg::*;

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

   cfg_type              cfg_ff;
   logic                 csr_wr;
   logic                 q_empty, q_pop, q_mode;
   logic [SET_W-1:0]     q_set;
   logic [ADDR_BITS-1:0] q_tag;
   rsp_type              rsp;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_size_log2 <= 3'd5;
         cfg_ff.set_count_log2 <= 4'd6;
         cfg_ff.ways_in_use    <= 4'd4;
         cfg_ff.write_policy   <= WP_WRITE_BACK;
         cfg_ff.replace_policy <= RP_LRU;
         cfg_ff.hit_time       <= 16'd1;
         cfg_ff.miss_penalty   <= 16'd100;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_LINE_SIZE_LOG2: cfg_ff.line_size_log2 <= csr_wdata[2:0];
            CSR_SET_COUNT_LOG2: cfg_ff.set_count_log2 <= csr_wdata[3:0];
            CSR_WAYS_IN_USE:    cfg_ff.ways_in_use    <= csr_wdata[3:0];
            CSR_WRITE_POLICY:   cfg_ff.write_policy   <= csr_wdata[0];
            CSR_REPLACE_POLICY: cfg_ff.replace_policy <= csr_wdata[1:0];
            CSR_HIT_TIME:       cfg_ff.hit_time       <= csr_wdata;
            CSR_MISS_PENALTY:   cfg_ff.miss_penalty   <= csr_wdata;
            default: ;
         endcase
      end
   end

   sacm_front #(
      .MAX_SETS  (MAX_SETS),
      .ADDR_BITS (ADDR_BITS),
      .SET_W     (SET_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (req_push),
      .full      (req_full),
      .address   (req_address),
      .mode      (req_mode),
      .empty     (q_empty),
      .pop       (q_pop),
      .head_set  (q_set),
      .head_tag  (q_tag),
      .head_mode (q_mode)
   );

   sacm_back #(
      .MAX_WAYS   (MAX_WAYS),
      .MAX_SETS   (MAX_SETS),
      .ADDR_BITS  (ADDR_BITS),
      .STAMP_BITS (STAMP_BITS),
      .SET_W      (SET_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_write (csr_wr),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_set     (q_set),
      .q_tag     (q_tag),
      .q_mode    (q_mode),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_hit               = rsp.hit;
   assign rsp_hit_count         = rsp.hit_count;
   assign rsp_miss_count        = rsp.miss_count;
   assign rsp_elapsed_time      = rsp.elapsed_time;
   assign rsp_total_access_time = rsp.total_access_time;

endmodule

// ===== verif/sacm_checker.sv =====
// Checker for the cache tag model: watches the channels, predicts results and compares them.
module sacm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [31:0] req_address,
   input  logic        req_mode,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_hit,
   input  logic [31:0] rsp_hit_count,
   input  logic [31:0] rsp_miss_count,
   input  logic [47:0] rsp_elapsed_time,
   input  logic [47:0] rsp_total_access_time,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sacm_pkg::*;

   localparam int NWAYS = 8;
   localparam int NSETS = 256;

   // Predicted copy of the cache state
   cfg_type     cfg;
   bit          line_valid [NWAYS][NSETS];
   logic [31:0] line_tag   [NWAYS][NSETS];
   logic [47:0] fill_stamp [NWAYS][NSETS];
   logic [47:0] use_stamp  [NWAYS][NSETS];
   logic [47:0] clk_now;
   logic [31:0] hits, misses;
   logic [47:0] weighted;
   logic [15:0] lfsr;
   rsp_type     expected_rsp [$];

   // Work out the outcome of one access
   function automatic rsp_type lookup_access(logic [31:0] addr, logic is_write);
      int          sl, ways, set, victim;
      logic [31:0] line_no, tag;
      logic [47:0] best;
      logic [15:0] nx;
      bit          found;
      rsp_type     r;
      sl = cfg.set_count_log2 > 8 ? 8 : cfg.set_count_log2;
      ways = cfg.ways_in_use == 0 ? 1 : (cfg.ways_in_use > NWAYS ? NWAYS : cfg.ways_in_use);
      line_no = addr >> cfg.line_size_log2;
      set = line_no & ((32'd1 << sl) - 1);
      tag = line_no >> sl;
      found = 0;
      clk_now = clk_now + 48'd1;
      for (int w = 0; w < ways; w++) begin
         if (!found && line_valid[w][set] && line_tag[w][set] == tag) begin
            use_stamp[w][set] = clk_now;
            found = 1;
         end
      end
      if (found) begin
         hits = hits + 1;
         weighted = weighted + cfg.hit_time;
         if (is_write && cfg.write_policy == WP_WRITE_THROUGH) clk_now = clk_now + 48'd2;
      end else begin
         misses = misses + 1;
         weighted = weighted + cfg.miss_penalty;
         clk_now = clk_now + 48'd1;
         victim = ways;
         for (int w = ways - 1; w >= 0; w--) begin
            if (!line_valid[w][set]) victim = w;
         end
         if (victim == ways) begin
            if (ways == 1) begin
               victim = 0;
            end else if (cfg.replace_policy == RP_RANDOM) begin
               nx = lfsr >> 1;
               if (lfsr[0]) nx = nx ^ LFSR_TAPS;
               lfsr = nx;
               victim = lfsr % ways;
            end else begin
               victim = 0;
               best = (cfg.replace_policy == RP_FIFO) ? fill_stamp[0][set] : use_stamp[0][set];
               for (int w = 1; w < ways; w++) begin
                  if (cfg.replace_policy == RP_FIFO) begin
                     if (fill_stamp[w][set] < best) begin
                        best = fill_stamp[w][set];
                        victim = w;
                     end
                  end else if (use_stamp[w][set] < best) begin
                     best = use_stamp[w][set];
                     victim = w;
                  end
               end
            end
         end
         line_valid[victim][set] = 1;
         line_tag[victim][set] = tag;
         fill_stamp[victim][set] = clk_now;
         use_stamp[victim][set] = clk_now;
         if (is_write && cfg.write_policy == WP_WRITE_BACK) clk_now = clk_now + 48'd2;
      end
      r.hit = found;
      r.hit_count = hits;
      r.miss_count = misses;
      r.elapsed_time = clk_now;
      r.total_access_time = weighted;
      return r;
   endfunction

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         cfg = '{3'd5, 4'd6, 4'd4, WP_WRITE_BACK, RP_LRU, 16'd1, 16'd100};
         for (int w = 0; w < NWAYS; w++)
            for (int s = 0; s < NSETS; s++) line_valid[w][s] = 0;
         clk_now = '0;
         hits = '0;
         misses = '0;
         weighted = '0;
         lfsr = LFSR_SEED;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_SIZE_LOG2: cfg.line_size_log2 = csr_wdata[2:0];
               CSR_SET_COUNT_LOG2: cfg.set_count_log2 = csr_wdata[3:0];
               CSR_WAYS_IN_USE:    cfg.ways_in_use = csr_wdata[3:0];
               CSR_WRITE_POLICY:   cfg.write_policy = csr_wdata[0];
               CSR_REPLACE_POLICY: cfg.replace_policy = csr_wdata[1:0];
               CSR_HIT_TIME:       cfg.hit_time = csr_wdata;
               CSR_MISS_PENALTY:   cfg.miss_penalty = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) expected_rsp.push_back(lookup_access(req_address, req_mode));
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transaction");
               fail_count = fail_count + 1;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_hit !== exp_r.hit) begin
                  $error("hit: expected %0d actual %0d", exp_r.hit, rsp_hit);
                  fail_count = fail_count + 1;
               end
               if (rsp_hit_count !== exp_r.hit_count) begin
                  $error("hit_count: expected %0d actual %0d", exp_r.hit_count, rsp_hit_count);
                  fail_count = fail_count + 1;
               end
               if (rsp_miss_count !== exp_r.miss_count) begin
                  $error("miss_count: expected %0d actual %0d", exp_r.miss_count,
                         rsp_miss_count);
                  fail_count = fail_count + 1;
               end
               if (rsp_elapsed_time !== exp_r.elapsed_time) begin
                  $error("elapsed_time: expected %0d actual %0d", exp_r.elapsed_time,
                         rsp_elapsed_time);
                  fail_count = fail_count + 1;
               end
               if (rsp_total_access_time !== exp_r.total_access_time) begin
                  $error("total_access_time: expected %0d actual %0d",
                         exp_r.total_access_time, rsp_total_access_time);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: stimulus for the cache tag model, watchdog and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sacm_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [31:0] req_address = '0;
   logic        req_mode = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic        rsp_hit;
   logic [31:0] rsp_hit_count, rsp_miss_count;
   logic [47:0] rsp_elapsed_time, rsp_total_access_time;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending;
   int          idle_cycles = 0;
   bit          hold_rsp = 0;
   bit          stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   set_assoc_cache_tag_model_core dut (.*);
   sacm_checker chk (.*);

   // Random gap length: mostly short, now and then long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random pops, with a long hold-off when asked
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_pop <= 0;
      else rsp_pop <= ($urandom_range(0, 3) != 0);
   end

   // Watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Wait for all results, then let a random victim pick finish
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic access(logic [31:0] addr, logic wr);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_push <= 0;
         repeat (g) @(negedge clock);
      end
      req_address <= addr;
      req_mode <= wr;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic set_all(int ls, int sc, int wy, int wp, int rp, int ht, int mp);
      req_push <= 0;
      drain();
      write_csr(CSR_LINE_SIZE_LOG2, 16'(ls));
      write_csr(CSR_SET_COUNT_LOG2, 16'(sc));
      write_csr(CSR_WAYS_IN_USE, 16'(wy));
      write_csr(CSR_WRITE_POLICY, 16'(wp));
      write_csr(CSR_REPLACE_POLICY, 16'(rp));
      write_csr(CSR_HIT_TIME, 16'(ht));
      write_csr(CSR_MISS_PENALTY, 16'(mp));
      write_csr(3'd7, 16'($urandom));
   endtask

   // Random run on a small address pool so sets fill and hit
   task automatic random_phase(int n);
      logic [31:0] pool [16];
      for (int i = 0; i < 16; i++) pool[i] = $urandom;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 8) access(pool[$urandom_range(0, 15)] ^
                                              $urandom_range(0, 3),
                                              1'($urandom_range(0, 1)));
         else access($urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      // Directed: address extremes, reads and writes, repeat hits, same-set conflicts
      access(32'h0, 0);
      access(32'h0, 1);
      access(32'hFFFF_FFFF, 1);
      access(32'hFFFF_FFFF, 0);
      access(32'hAAAA_AAAA, 0);
      access(32'h5555_5555, 1);
      for (int i = 0; i < 6; i++) access(i << 11, i[0]);
      access(32'h0, 0);
      // Single way under write-through, LRU beyond range treated as LRU
      set_all(0, 0, 1, 1, 3, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 6; i++) access(i % 2, 1);
      // Zero ways, oversize sets, 128-byte lines, random policy
      set_all(7, 15, 0, 0, 0, 0, 0);
      access(32'h8000_0000, 1);
      access(32'h8000_0000, 1);
      // Long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         random_phase(20);
      join
      // Random phases across settings, the extremes among them
      set_all(2, 2, 8, 0, 0, 1, 100);
      random_phase(90);
      set_all(4, 3, 4, 1, 1, 3, 60000);
      random_phase(90);
      set_all(6, 8, 15, 0, 2, 65535, 0);
      random_phase(90);
      set_all(0, 1, 3, 1, 0, 7, 9);
      random_phase(90);
      set_all(3, 0, 2, 0, 1, 2, 200);
      random_phase(80);
      set_all(5, 6, 4, 0, 2, 1, 100);
      random_phase(80);
      req_push <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
